// ----- design/mqs_pkg.sv -----
// Shared types and constants for the median quickselect block.
// No dependencies.

package mqs_pkg;

    localparam int unsigned SAMPLE_W = 32;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SAMPLE_W:0]   t_sum;

endpackage

// ----- design/mqs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module mqs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/median_quickselect.sv -----
// Median of a set of signed samples, found by quickselect over a sample RAM.
// Depends on mqs_pkg and mqs_ram.
//
// Usage:
// Input channel (i_valid / o_stall) carries one sample per request with
// i_last_sample marking the end of a set. Samples load at one per cycle
// while the block is in its load phase. Samples past MAX_SAMPLES are dropped
// and flagged on o_count_overflow.
// After the last sample the input stalls while Lomuto partition passes run
// against the RAM. Each scanned element is read, then compared; a swap
// writes both entries in turn. Selection is limited by the single RAM
// read port. Even counts then scan the entries below the middle for the
// lower middle value and average it with the upper one.
// Output channel (o_valid / i_stall) carries one result per set from an
// output register; the next set may load while that result waits.
// Reset (synchronous, active low) empties the set and clears the output valid.
// The RAM contents are not cleared; only loaded entries are read.

module median_quickselect #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample_value,
    input  logic        i_last_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_median_value,
    output logic        o_count_overflow
);

    localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [AW-1:0] A_ONE   = AW'(1);
    localparam logic [CW-1:0] C_ONE   = CW'(1);

    typedef enum logic [3:0] {
        S_LOAD, S_TOP, S_PIV, S_SCAN, S_CMP, S_SWPA, S_SWPB,
        S_FINA, S_FINB, S_DECIDE, S_UPPER, S_LRD, S_LCMP, S_AVG, S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic            r_set_ovf;
    logic [CW-1:0]   r_n;
    logic [AW-1:0]   r_lo, r_hi, r_k, r_dst, r_scan, r_i;
    mqs_pkg::t_sample r_piv, r_tmp, r_upper, r_lower, r_res;
    logic            r_out_vld;
    logic [31:0]     r_out_med;
    logic            r_out_ovf;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;
    mqs_pkg::t_sample     rd;

    logic                 in_acc;
    logic                 room;
    logic [CW-1:0]        n_cnt;
    logic [AW-1:0]        n_i;
    mqs_pkg::t_sum        sum;
    mqs_pkg::t_sum        sum_adj;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_LOAD);
    assign room    = (r_count < CNT_MAX);
    assign n_cnt   = room ? (r_count + C_ONE) : r_count;
    assign rd      = mqs_pkg::t_sample'(ram_rdata);
    assign n_i     = r_i + A_ONE;
    assign sum     = {r_lower[31], r_lower} + {r_upper[31], r_upper};
    assign sum_adj = sum + {{32{1'b0}}, sum[32]};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = i_sample_value;
        ram_re    = 1'b0;
        ram_raddr = r_hi;
        case (r_state)
            S_LOAD: begin
                ram_we = in_acc && room;
            end
            S_TOP: begin
                ram_re    = 1'b1;
                ram_raddr = (r_lo < r_hi) ? r_hi : r_k;
            end
            S_SCAN: begin
                ram_re    = (r_scan < r_hi) || (r_dst != r_hi);
                ram_raddr = (r_scan < r_hi) ? r_scan : r_dst;
            end
            S_CMP: begin
                ram_re    = (rd < r_piv) && (r_dst != r_scan);
                ram_raddr = r_dst;
            end
            S_SWPA: begin
                ram_we    = 1'b1;
                ram_waddr = r_scan;
                ram_wdata = ram_rdata;
            end
            S_SWPB: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = r_tmp;
            end
            S_FINA: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                ram_wdata = ram_rdata;
            end
            S_FINB: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = r_piv;
            end
            S_DECIDE: begin
                ram_re    = (r_dst == r_k);
                ram_raddr = r_k;
            end
            S_LRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_i;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    mqs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_stall && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_last_sample) begin
                            r_count   <= '0;
                            r_ovf     <= 1'b0;
                            r_set_ovf <= r_ovf || !room;
                            r_n       <= n_cnt;
                            r_lo      <= '0;
                            r_hi      <= AW'(n_cnt - C_ONE);
                            r_k       <= AW'(n_cnt >> 1);
                            r_state   <= S_TOP;
                        end else begin
                            r_count <= n_cnt;
                            r_ovf   <= r_ovf || !room;
                        end
                    end
                end
                S_TOP: begin
                    r_state <= (r_lo < r_hi) ? S_PIV : S_UPPER;
                end
                S_PIV: begin
                    r_piv   <= rd;
                    r_dst   <= r_lo;
                    r_scan  <= r_lo;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_scan < r_hi) begin
                        r_state <= S_CMP;
                    end else if (r_dst != r_hi) begin
                        r_state <= S_FINA;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_CMP: begin
                    if (rd < r_piv) begin
                        if (r_dst == r_scan) begin
                            r_dst   <= r_dst + A_ONE;
                            r_scan  <= r_scan + A_ONE;
                            r_state <= S_SCAN;
                        end else begin
                            r_tmp   <= rd;
                            r_state <= S_SWPA;
                        end
                    end else begin
                        r_scan  <= r_scan + A_ONE;
                        r_state <= S_SCAN;
                    end
                end
                S_SWPA: begin
                    r_state <= S_SWPB;
                end
                S_SWPB: begin
                    r_dst   <= r_dst + A_ONE;
                    r_scan  <= r_scan + A_ONE;
                    r_state <= S_SCAN;
                end
                S_FINA: begin
                    r_state <= S_FINB;
                end
                S_FINB: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_dst == r_k) begin
                        r_state <= S_UPPER;
                    end else if (r_dst > r_k) begin
                        r_hi    <= r_dst - A_ONE;
                        r_state <= S_TOP;
                    end else begin
                        r_lo    <= r_dst + A_ONE;
                        r_state <= S_TOP;
                    end
                end
                S_UPPER: begin
                    r_upper <= rd;
                    r_res   <= rd;
                    r_i     <= '0;
                    r_state <= r_n[0] ? S_OUT : S_LRD;
                end
                S_LRD: begin
                    r_state <= S_LCMP;
                end
                S_LCMP: begin
                    if ((r_i == '0) || (rd > r_lower)) begin
                        r_lower <= rd;
                    end
                    r_i     <= n_i;
                    r_state <= (n_i == r_k) ? S_AVG : S_LRD;
                end
                S_AVG: begin
                    r_res   <= mqs_pkg::t_sample'(sum_adj >>> 1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_vld || !i_stall) begin
                        r_out_vld <= 1'b1;
                        r_out_med <= r_res;
                        r_out_ovf <= r_set_ovf;
                        r_state   <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid          = r_out_vld;
    assign o_median_value   = r_out_med;
    assign o_count_overflow = r_out_ovf;

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_sample) |=> o_stall)
        else $error("input not stalled after end of set");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("sample count beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_dst <= r_scan) && (r_scan <= r_hi)))
        else $error("partition indices out of order");

    a_set_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOP) |-> (r_n != '0))
        else $error("selection started on an empty set");

endmodule
